FILE: rtl/core/temporal_frame_averager_macros.svh
// assertion macros shared by the checker of the temporal frame averager
// no dependencies; every macro samples on clk_i and is disabled while rst_ni is low
`ifndef TEMPORAL_FRAME_AVERAGER_MACROS_SVH
`define TEMPORAL_FRAME_AVERAGER_MACROS_SVH

// same-cycle implication
`define TFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tfa_pkg.sv
// types and constants of the temporal frame averager
// used by tfa_ctrl, tfa_dpath and temporal_frame_averager; no dependencies
`default_nettype none

package tfa_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned AVG_W      = 8;
  localparam int unsigned GRP_CFG_W  = 9;
  localparam int unsigned PIX_CFG_W  = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_GROUP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXELS = 2'd1;

  localparam logic [AVG_W-1:0] AVG_MAX = 8'd255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV,
    ST_PUT
  } tfa_state_e;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_step;
    logic out_load;
  } tfa_cmd_t;

  typedef struct packed {
    logic last_frame;
    logic div_last;
  } tfa_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/temporal_frame_averager.sv
// temporal frame averager with decimation
// pixels of equal-sized frames enter in raster order on the s_axis channel. every group
// of frames_per_output frames is summed per pixel position; while the group's last
// frame passes, each pixel yields one word on m_axis: floor(sum / N) clamped to 255,
// with tlast on the last pixel of the frame. other frames of a group give no word.
// the cfg channel writes frames_per_output (index 0) and pixels_per_frame (index 1);
// any write to either restarts at the first pixel of a new group. cfg_ready_o is always
// high; write only while no word is in flight.
// each pixel's sum is read from memory as the pixel is accepted and written back in the
// update step; in the group's last frame the bit-serial divider then makes one quotient
// bit per cycle and the word is loaded into the output register. the block takes a new
// pixel only after the previous one is through.
// reset clears the positions and loads N = 1 and min(MAX_PIXELS, 65536) pixels per
// frame; the sum memory is not cleared, since the first frame of each group overwrites it.
// a stalled receiver holds the output register; pixels that yield no word are still
// taken, the next one that does is divided, then the block waits until the held word leaves.
// depends on tfa_pkg, tfa_ctrl, tfa_dpath
`default_nettype none

module temporal_frame_averager #(
  parameter int unsigned MAX_PIXELS = 65536,
  parameter int unsigned MAX_GROUP  = 256
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // cfg write channel
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [tfa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [tfa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // pixel input
  input  wire                            s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire  [7:0]                     s_axis_tdata_i,   // [7:0] pixel_in
  // averaged output
  output logic                           m_axis_tvalid_o,
  input  wire                            m_axis_tready_i,
  output logic [7:0]                     m_axis_tdata_o,   // [7:0] pixel_avg
  output logic                           m_axis_tlast_o    // frame_last
);

  tfa_pkg::tfa_cmd_t  cmd;
  tfa_pkg::tfa_stat_t stat;

  assign cfg_ready_o = 1'b1;

  tfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tfa_dpath #(
    .MAX_PIXELS (MAX_PIXELS),
    .MAX_GROUP  (MAX_GROUP)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_in_i   (s_axis_tdata_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .pixel_avg_o  (m_axis_tdata_o),
    .frame_last_o (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/tfa_ctrl.sv
// sequencer of the temporal frame averager: accept, update, divide, put
// depends on tfa_pkg; drives the datapath through tfa_cmd_t
`default_nettype none

module tfa_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  input  tfa_pkg::tfa_stat_t stat_i,
  output tfa_pkg::tfa_cmd_t  cmd_o
);

  tfa_pkg::tfa_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tfa_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tfa_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = tfa_pkg::ST_UPD;
        end
      end
      tfa_pkg::ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = stat_i.last_frame ? tfa_pkg::ST_DIV : tfa_pkg::ST_IDLE;
      end
      tfa_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = tfa_pkg::ST_PUT;
        end
      end
      tfa_pkg::ST_PUT: begin
        // the output register may be refilled in the cycle its word is taken
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = tfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/tfa_dpath.sv
// datapath of the temporal frame averager: settings, position counters,
// per-pixel sum memory, restoring divider and output register; depends on tfa_pkg
`default_nettype none

module tfa_dpath #(
  parameter int unsigned MAX_PIXELS = 65536,
  parameter int unsigned MAX_GROUP  = 256
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_valid_i,
  input  wire  [tfa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [tfa_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire  [tfa_pkg::PIX_W-1:0]        pixel_in_i,
  input  tfa_pkg::tfa_cmd_t                cmd_i,
  output tfa_pkg::tfa_stat_t               stat_o,
  output logic [tfa_pkg::AVG_W-1:0]        pixel_avg_o,
  output logic                             frame_last_o
);

  localparam int unsigned ADDR_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned PCNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned GRP_W   = $clog2(MAX_GROUP + 1);
  localparam int unsigned FRM_W   = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int unsigned SUM_W   = $clog2(MAX_GROUP * 255 + 1);
  localparam int unsigned CNT_W   = $clog2(SUM_W);
  localparam int unsigned PIX_RST = (MAX_PIXELS < 65536) ? MAX_PIXELS : 65536;

  // settings, held as effective values
  logic [GRP_W-1:0]  grp_q, grp_d;
  logic [PCNT_W-1:0] ppf_q, ppf_d;
  logic              cfg_hit;
  int unsigned       cfg_grp, cfg_ppf;

  // stream position
  logic [ADDR_W-1:0] pos_q;
  logic [FRM_W-1:0]  frm_q;
  logic              last_pix, last_frm;

  // word in flight
  logic [tfa_pkg::PIX_W-1:0] pix_q;
  logic [ADDR_W-1:0]         addr_q;
  logic                      first_q, lpix_q, lfrm_q;

  // sum memory
  logic [SUM_W-1:0] sum_mem [MAX_PIXELS];
  logic [SUM_W-1:0] rd_q;
  logic [SUM_W-1:0] sum_new;

  // divider
  logic [GRP_W-1:0] rem_q;
  logic [SUM_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic [GRP_W:0]   trial, diff;
  logic             ge;
  logic [SUM_W:0]   quo_x;

  always_comb begin
    cfg_grp = 32'(cfg_data_i[tfa_pkg::GRP_CFG_W-1:0]);
    cfg_ppf = 32'(cfg_data_i[tfa_pkg::PIX_CFG_W-1:0]);
    if (cfg_grp == 0) begin
      grp_d = GRP_W'(1);
    end else if (cfg_grp > MAX_GROUP) begin
      grp_d = GRP_W'(MAX_GROUP);
    end else begin
      grp_d = GRP_W'(cfg_grp);
    end
    if (cfg_ppf == 0) begin
      ppf_d = PCNT_W'(1);
    end else if (cfg_ppf > MAX_PIXELS) begin
      ppf_d = PCNT_W'(MAX_PIXELS);
    end else begin
      ppf_d = PCNT_W'(cfg_ppf);
    end
    cfg_hit = cfg_valid_i &&
              (cfg_index_i == tfa_pkg::REG_GROUP || cfg_index_i == tfa_pkg::REG_PIXELS);
  end

  assign last_pix = (32'(pos_q) + 32'd1) >= 32'(ppf_q);
  assign last_frm = (32'(frm_q) + 32'd1) >= 32'(grp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= GRP_W'(1);
      ppf_q <= PCNT_W'(PIX_RST);
      pos_q <= '0;
      frm_q <= '0;
    end else if (cfg_hit) begin
      if (cfg_index_i == tfa_pkg::REG_GROUP) begin
        grp_q <= grp_d;
      end
      if (cfg_index_i == tfa_pkg::REG_PIXELS) begin
        ppf_q <= ppf_d;
      end
      pos_q <= '0;
      frm_q <= '0;
    end else if (cmd_i.accept) begin
      if (last_pix) begin
        pos_q <= '0;
        frm_q <= last_frm ? '0 : frm_q + FRM_W'(1);
      end else begin
        pos_q <= pos_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfrm_q <= 1'b0;
    end else if (cmd_i.accept) begin
      lfrm_q <= last_frm;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q   <= pixel_in_i;
      addr_q  <= pos_q;
      first_q <= (frm_q == '0);
      lpix_q  <= last_pix;
    end
  end

  assign sum_new = first_q ? SUM_W'(pix_q) : rd_q + SUM_W'(pix_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q <= sum_mem[pos_q];
    end
    if (cmd_i.update) begin
      sum_mem[addr_q] <= sum_new;
    end
  end

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign ge    = trial >= {1'b0, grp_q};
  assign diff  = trial - {1'b0, grp_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.update) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      rem_q <= '0;
      quo_q <= sum_new;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[GRP_W-1:0] : trial[GRP_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], ge};
    end
  end

  assign stat_o.last_frame = lfrm_q;
  assign stat_o.div_last   = (cnt_q == CNT_W'(SUM_W - 1));

  assign quo_x = {1'b0, quo_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pixel_avg_o  <= (|quo_x[SUM_W:tfa_pkg::AVG_W]) ? tfa_pkg::AVG_MAX
                                                      : quo_q[tfa_pkg::AVG_W-1:0];
      frame_last_o <= lpix_q;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tfa_checker.sv
// port-level checks of the temporal frame averager, bound to the top level
// depends on temporal_frame_averager_macros.svh and temporal_frame_averager
`default_nettype none
`include "temporal_frame_averager_macros.svh"

module tfa_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       s_axis_tvalid_i,
  input wire       s_axis_tready_o,
  input wire       m_axis_tvalid_o,
  input wire       m_axis_tready_i,
  input wire [7:0] m_axis_tdata_o,
  input wire       m_axis_tlast_o
);

  logic       in_word;
  logic       out_stall;
  logic [8:0] out_word;

  assign in_word   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_word  = {m_axis_tlast_o, m_axis_tdata_o};

  // an accepted pixel always needs its sum written back before the next one
  `TFA_ASSERT_NEXT(a_one_word_in_flight, in_word, !s_axis_tready_o, "pixel during update")

  // a new output word comes only out of the put step, never while input is open
  `TFA_ASSERT_NOW(a_load_put, $rose(m_axis_tvalid_o), $past(!s_axis_tready_o), "load while open")

  `TFA_ASSERT_NEXT(a_out_valid_hold, out_stall, m_axis_tvalid_o, "word dropped while stalled")

  `TFA_ASSERT_NEXT(a_out_data_hold, out_stall, $stable(out_word), "word changed while stalled")

endmodule

bind temporal_frame_averager tfa_checker u_tfa_checker (.*);

`default_nettype wire
